// ===== src/lzrw_pkg.sv =====
package lzrw_pkg;

   // history window
   localparam int WIN_DEPTH = 4096;
   localparam int WIN_BITS  = $clog2(WIN_DEPTH);
   localparam int OFF_BITS  = 12;

   // byte counter and capacity register
   localparam int COUNT_BITS = 24;
   localparam int CAP_BITS   = 24;
   localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS + 1 : CAP_BITS + 1;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_BITS  = $clog2(FIFO_DEPTH);
   localparam logic [FIFO_BITS:0] FIFO_FULL = (FIFO_BITS + 1)'(FIFO_DEPTH);

   // status codes
   localparam logic [2:0] STS_DATA   = 3'd0;
   localparam logic [2:0] STS_OK     = 3'd1;
   localparam logic [2:0] STS_SHORT  = 3'd2;
   localparam logic [2:0] STS_TRUNC  = 3'd3;
   localparam logic [2:0] STS_CAP    = 3'd4;
   localparam logic [2:0] STS_OFFSET = 3'd5;

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_ITEM,
      PH_CTRL_HIGH,
      PH_COPY_B,
      PH_RAW
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_STATUS
   } state_type;

   typedef struct packed {
      logic [7:0]          out_data;
      logic                data_valid;
      logic [2:0]          status;
      logic [CAP_BITS-1:0] produced_total;
      logic                run_end;
   } rsp_item_type;

   typedef struct packed {
      logic                en;
      logic [WIN_BITS-1:0] addr;
      logic [7:0]          data;
   } win_wr_type;

   typedef struct packed {
      logic                en;
      logic [WIN_BITS-1:0] addr;
   } win_rd_type;

endpackage

// ===== src/lzrw_window.sv =====
module lzrw_window import lzrw_pkg::*; (
   input  logic       clock,
   input  win_wr_type win_wr,
   input  win_rd_type win_rd,
   output logic [7:0] win_q
);

   logic [7:0] mem [WIN_DEPTH];
   logic [7:0] q_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (win_wr.en) begin
         mem[win_wr.addr] <= win_wr.data;
      end
      if (win_rd.en) begin
         q_ff <= mem[win_rd.addr];
      end
   end

   assign win_q = q_ff;

endmodule

// ===== src/lzrw_rsp_fifo.sv =====
module lzrw_rsp_fifo import lzrw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_en,
   input  rsp_item_type       push_item,
   input  logic               pop_en,
   output rsp_item_type       head_item,
   output logic               head_valid,
   output logic [FIFO_BITS:0] fifo_count
);

   rsp_item_type         slot_ff [FIFO_DEPTH];
   logic [FIFO_BITS-1:0] head_ff, head_in;
   logic [FIFO_BITS-1:0] tail_ff, tail_in;
   logic [FIFO_BITS:0]   count_ff, count_in;

   always_comb begin
      head_in  = head_ff + FIFO_BITS'(pop_en);
      tail_in  = tail_ff + FIFO_BITS'(push_en);
      count_in = count_ff + (FIFO_BITS + 1)'(push_en) - (FIFO_BITS + 1)'(pop_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         slot_ff[tail_ff] <= push_item;
      end
   end

   assign head_item  = slot_ff[head_ff];
   assign head_valid = (count_ff != '0);
   assign fifo_count = count_ff;

endmodule

// ===== src/lzrw_engine.sv =====
module lzrw_engine import lzrw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_in_last,
   input  logic [CAP_BITS-1:0] out_capacity,
   input  logic [FIFO_BITS:0]  fifo_count,
   output logic                push_en,
   output rsp_item_type        push_item,
   output win_wr_type          win_wr,
   output win_rd_type          win_rd,
   input  logic [7:0]          win_q
);

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [15:0]           cw_ff, cw_in;
   logic [4:0]            left_ff, left_in;
   logic                  copy_mode_ff, copy_mode_in;
   logic [7:0]            held_ff, held_in;
   logic [2:0]            err_ff, err_in;
   logic [COUNT_BITS-1:0] produced_ff, produced_in;
   logic [WIN_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [WIN_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [3:0]            remain_ff, remain_in;
   logic                  last_pend_ff, last_pend_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic                  rd_final_ff, rd_final_in;
   logic                  rd_fwd_ff, rd_fwd_in;
   logic [7:0]            last_wr_ff, last_wr_in;

   logic                  accept;
   logic                  can_take;
   logic                  lit_go;
   logic                  copy_go;
   logic                  issue;
   logic                  status_go;
   logic [FIFO_BITS:0]    credit_used;
   logic [7:0]            arr_byte;
   logic [OFF_BITS-1:0]   offset;
   logic [CMP_BITS-1:0]   cnt_w, cap_w, lim_w, len_w, off_w;
   logic                  lit_fits, copy_fits, off_ok;

   // handshake and limits
   always_comb begin
      can_take  = (state_ff == ST_IDLE) && !rd_pend_ff && (fifo_count < FIFO_FULL);
      req_stall = !can_take;
      accept    = req_valid && can_take;

      cnt_w = CMP_BITS'(produced_ff);
      cap_w = CMP_BITS'(out_capacity);
      lim_w = (cap_w < CMP_BITS'({COUNT_BITS{1'b1}})) ? cap_w
                                                      : CMP_BITS'({COUNT_BITS{1'b1}});
      offset    = {held_ff[7:4], req_in_byte};
      off_w     = CMP_BITS'(offset);
      len_w     = CMP_BITS'(held_ff[3:0]) + CMP_BITS'(1);
      lit_fits  = cnt_w < lim_w;
      copy_fits = (cnt_w + len_w) <= lim_w;
      off_ok    = (offset != '0) && (off_w <= cnt_w);

      credit_used = fifo_count + (FIFO_BITS + 1)'(rd_pend_ff);
      issue       = (state_ff == ST_COPY) && (credit_used < FIFO_FULL);
      status_go   = (state_ff == ST_STATUS) && !rd_pend_ff && (fifo_count < FIFO_FULL);
   end

   // byte parser
   always_comb begin
      phase_in     = phase_ff;
      cw_in        = cw_ff;
      left_in      = left_ff;
      copy_mode_in = copy_mode_ff;
      held_in      = held_ff;
      err_in       = err_ff;
      lit_go       = 1'b0;
      copy_go      = 1'b0;
      if (accept && (err_ff == STS_DATA)) begin
         unique case (phase_ff)
            PH_HDR0: begin
               copy_mode_in = (req_in_byte == 8'd1);
               phase_in     = PH_HDR1;
            end
            PH_HDR1: phase_in = PH_HDR2;
            PH_HDR2: phase_in = PH_HDR3;
            PH_HDR3: phase_in = copy_mode_ff ? PH_RAW : PH_ITEM;
            PH_RAW: begin
               if (lit_fits) begin
                  lit_go = 1'b1;
               end else begin
                  err_in = STS_CAP;
               end
            end
            PH_ITEM: begin
               if (left_ff == '0) begin
                  cw_in    = {8'd0, req_in_byte};
                  phase_in = PH_CTRL_HIGH;
               end else if (cw_ff[0]) begin
                  held_in  = req_in_byte;
                  phase_in = PH_COPY_B;
               end else begin
                  if (lit_fits) begin
                     lit_go = 1'b1;
                  end else begin
                     err_in = STS_CAP;
                  end
                  cw_in   = cw_ff >> 1;
                  left_in = left_ff - 5'd1;
               end
            end
            PH_CTRL_HIGH: begin
               cw_in    = {req_in_byte, cw_ff[7:0]};
               left_in  = 5'd16;
               phase_in = PH_ITEM;
            end
            PH_COPY_B: begin
               // capacity is tested before the offset
               if (!copy_fits) begin
                  err_in = STS_CAP;
               end else if (!off_ok) begin
                  err_in = STS_OFFSET;
               end else begin
                  copy_go = 1'b1;
               end
               cw_in    = cw_ff >> 1;
               left_in  = left_ff - 5'd1;
               phase_in = PH_ITEM;
            end
         endcase
      end
      if (accept && req_in_last && (err_in == STS_DATA)) begin
         if (phase_ff == PH_HDR0 || phase_ff == PH_HDR1 ||
             phase_ff == PH_HDR2 || phase_ff == PH_HDR3) begin
            err_in = STS_SHORT;
         end else if (phase_in == PH_CTRL_HIGH || phase_in == PH_COPY_B) begin
            err_in = STS_TRUNC;
         end
      end
      // block ends with its status transfer
      if (status_go) begin
         phase_in     = PH_HDR0;
         cw_in        = '0;
         left_in      = '0;
         copy_mode_in = 1'b0;
         held_in      = '0;
         err_in       = STS_DATA;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (copy_go) begin
                  state_in = ST_COPY;
               end else if (req_in_last) begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_COPY: begin
            if (issue && (remain_ff == '0)) begin
               state_in = last_pend_ff ? ST_STATUS : ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (status_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: window ports and result pushes
   always_comb begin
      arr_byte = rd_fwd_ff ? last_wr_ff : win_q;

      win_wr.en   = rd_pend_ff || lit_go;
      win_wr.addr = wr_ptr_ff;
      win_wr.data = rd_pend_ff ? arr_byte : req_in_byte;
      win_rd.en   = issue;
      win_rd.addr = rd_ptr_ff;

      push_en   = win_wr.en || status_go;
      push_item = '0;
      if (status_go) begin
         push_item.status         = (err_ff == STS_DATA) ? STS_OK : err_ff;
         push_item.produced_total = (err_ff == STS_DATA) ? CAP_BITS'(produced_ff) : '0;
         push_item.run_end        = 1'b1;
      end else begin
         push_item.out_data   = win_wr.data;
         push_item.data_valid = 1'b1;
         push_item.status     = STS_DATA;
         push_item.run_end    = rd_pend_ff ? rd_final_ff : !req_in_last;
      end
   end

   // counters, copy sequencer and read pipeline
   always_comb begin
      produced_in = status_go ? '0 : produced_ff + COUNT_BITS'(win_wr.en);
      wr_ptr_in   = wr_ptr_ff + WIN_BITS'(win_wr.en);
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      last_pend_in = last_pend_ff;
      if (copy_go) begin
         rd_ptr_in    = wr_ptr_ff - WIN_BITS'(offset);
         remain_in    = held_ff[3:0];
         last_pend_in = req_in_last;
      end else if (issue) begin
         rd_ptr_in = rd_ptr_ff + WIN_BITS'(1);
         remain_in = remain_ff - 4'd1;
      end
      rd_pend_in  = issue;
      rd_final_in = issue && (remain_ff == '0) && !last_pend_ff;
      // offset one reads the byte being written in the same cycle
      rd_fwd_in   = issue && win_wr.en && (rd_ptr_ff == wr_ptr_ff);
      last_wr_in  = win_wr.en ? win_wr.data : last_wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_HDR0;
         cw_ff        <= '0;
         left_ff      <= '0;
         copy_mode_ff <= 1'b0;
         held_ff      <= '0;
         err_ff       <= STS_DATA;
         produced_ff  <= '0;
         wr_ptr_ff    <= '0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cw_ff        <= cw_in;
         left_ff      <= left_in;
         copy_mode_ff <= copy_mode_in;
         held_ff      <= held_in;
         err_ff       <= err_in;
         produced_ff  <= produced_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      remain_ff    <= remain_in;
      last_pend_ff <= last_pend_in;
      rd_final_ff  <= rd_final_in;
      rd_fwd_ff    <= rd_fwd_in;
      last_wr_ff   <= last_wr_in;
   end

   a_arrival_room: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (fifo_count < FIFO_FULL))
      else $error("window read returned with no queue room");

   a_status_drained: assert property (@(posedge clock) disable iff (reset)
      (push_en && !push_item.data_valid) |-> !rd_pend_ff)
      else $error("status pushed ahead of copy bytes");

   a_copy_no_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY) |-> (err_ff == STS_DATA))
      else $error("copy running with an error latched");

   a_block_cleared: assert property (@(posedge clock) disable iff (reset)
      status_go |=> (produced_ff == '0 && phase_ff == PH_HDR0 && err_ff == STS_DATA))
      else $error("block state not cleared after status");

endmodule

// ===== src/lzrw1_decompressor.sv =====
// channel  dir  handshake                 payload
// req      in   req_valid / req_stall     req_in_byte[7:0], req_in_last
// rsp      out  rsp_valid / rsp_stall     rsp_out_data[7:0], rsp_data_valid, rsp_status[2:0],
//                                         rsp_produced_total[23:0], rsp_run_end
// csr      in   csr_valid / csr_ready     csr_out_capacity[23:0]
//
// header, control and literal bytes are each handled as they are accepted; a byte that closes
// the block is followed by its status transfer
// a copy item is taken as its two bytes, then reads the window once for each byte of its
// length and drains the last read, as its bytes come one per cycle, while the result
// queue has room, through the single read port of the history window
// reset is synchronous; it clears the parser, counters and result queue, not the window
// results wait in a four-entry queue, so a stall on rsp holds the copy engine only once the
// queue and a window read in flight fill it; req_stall is high whenever an item is still in progress

module lzrw1_decompressor import lzrw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_in_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_data,
   output logic                rsp_data_valid,
   output logic [2:0]          rsp_status,
   output logic [CAP_BITS-1:0] rsp_produced_total,
   output logic                rsp_run_end,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_BITS-1:0] csr_out_capacity
);

   logic [CAP_BITS-1:0] capacity_ff, capacity_in;
   logic                push_en;
   rsp_item_type        push_item;
   rsp_item_type        head_item;
   logic [FIFO_BITS:0]  fifo_count;
   logic                pop_en;
   win_wr_type          win_wr;
   win_rd_type          win_rd;
   logic [7:0]          win_q;

   // capacity register; the user must write it only while the block is idle, which the block itself does not enforce
   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_out_capacity : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= {CAP_BITS{1'b1}};
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // parser and copy sequencer
   lzrw_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .out_capacity (capacity_ff),
      .fifo_count   (fifo_count),
      .push_en      (push_en),
      .push_item    (push_item),
      .win_wr       (win_wr),
      .win_rd       (win_rd),
      .win_q        (win_q)
   );

   // history window, one write and one registered read per cycle
   lzrw_window u_window (
      .clock  (clock),
      .win_wr (win_wr),
      .win_rd (win_rd),
      .win_q  (win_q)
   );

   // result queue decouples the engine from rsp stalls
   assign pop_en = rsp_valid && !rsp_stall;

   lzrw_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (push_en),
      .push_item  (push_item),
      .pop_en     (pop_en),
      .head_item  (head_item),
      .head_valid (rsp_valid),
      .fifo_count (fifo_count)
   );

   assign rsp_out_data       = head_item.out_data;
   assign rsp_data_valid     = head_item.data_valid;
   assign rsp_status         = head_item.status;
   assign rsp_produced_total = head_item.produced_total;
   assign rsp_run_end        = head_item.run_end;

endmodule

// ===== tb/tb_lzrw1_decompressor.sv =====
`timescale 1ns / 100ps

module tb_lzrw1_decompressor;
   import lzrw_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;    // a copy item plus its window read drain, with margin
   localparam int LONG_HOLD    = 120;   // receiver hold-off that backs the block up
   localparam int MAX_REPORTS  = 60;

   // no latched decode error
   localparam logic [2:0] ERR_NONE = 3'd0;

   // how a generated block closes
   typedef enum int {
      BLK_OK,
      BLK_CUT_CTRL,
      BLK_CUT_COPY
   } blk_end_type;

   // one compressed byte on its way to the block
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } comp_byte_type;

   // dut ports, every input known from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_in_byte = 8'h00;
   logic                req_in_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_out_data;
   logic                rsp_data_valid;
   logic [2:0]          rsp_status;
   logic [CAP_BITS-1:0] rsp_produced_total;
   logic                rsp_run_end;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_BITS-1:0] csr_out_capacity = '0;

   // stimulus and expected decoder output
   comp_byte_type compressed_q[$];
   rsp_item_type  decoded_q[$];
   logic [7:0]    blk[$];              // block under construction
   int            bytes_queued = 0;
   int            bytes_taken = 0;
   int            body_bytes = 0;      // bytes past the ignored header bytes
   int unsigned   lz_made = 0;         // generator's own tally of bytes a block will produce
   int            fail_count = 0;
   int            cycle_count = 0;

   // handshake bookkeeping shared between the clocked processes
   logic req_taken = 1'b0;
   int   req_gap = 0;
   int   rsp_hold = 0;
   logic squeeze_rsp = 1'b0;
   logic squeeze_done = 1'b0;
   logic calm = 1'b0;

   // decoder state mirrored for prediction
   logic [7:0]          win_mem [WIN_DEPTH];
   logic [WIN_BITS-1:0] win_ptr = '0;
   logic [COUNT_BITS-1:0] out_count = '0;
   logic [15:0]         ctrl_bits = '0;
   logic [4:0]          ctrl_left = '0;
   phase_type           dec_phase = PH_HDR0;
   logic                raw_mode = 1'b0;
   logic [7:0]          copy_hi = '0;
   logic [2:0]          dec_err = ERR_NONE;
   logic [CAP_BITS-1:0] cap_reg = '1;

   lzrw1_decompressor uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_in_last        (req_in_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_data       (rsp_out_data),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_status         (rsp_status),
      .rsp_produced_total (rsp_produced_total),
      .rsp_run_end        (rsp_run_end),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_out_capacity   (csr_out_capacity)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // produced byte: into the window and out as a data result
   task automatic store_byte(input logic [7:0] b);
      rsp_item_type r;
      win_mem[win_ptr] = b;
      win_ptr = win_ptr + 1'b1;
      out_count = out_count + 1'b1;
      r = '0;
      r.out_data = b;
      r.data_valid = 1'b1;
      r.status = STS_DATA;
      decoded_q.push_back(r);
   endtask

   // literal or pass-through byte, refused once the capacity is used up
   task automatic take_literal(input logic [7:0] b);
      if (out_count >= cap_reg) begin
         dec_err = STS_CAP;
      end else begin
         store_byte(b);
      end
   endtask

   // copy item: capacity is checked before the offset, and a refused copy emits nothing
   task automatic run_copy(input logic [7:0] lo);
      logic [OFF_BITS-1:0] offset;
      logic [WIN_BITS-1:0] rd_addr;
      int unsigned len;
      offset = {copy_hi[7:4], lo};
      len = copy_hi[3:0] + 1;
      if (out_count + len > cap_reg) begin
         dec_err = STS_CAP;
      end else if (offset == 0 || offset > out_count) begin
         dec_err = STS_OFFSET;
      end else begin
         // byte by byte, so an overlapping copy repeats the pattern
         for (int i = 0; i < len; i++) begin
            rd_addr = win_ptr - offset;
            store_byte(win_mem[rd_addr]);
         end
      end
   endtask

   // one accepted compressed byte: queue every result it causes
   task automatic decode_byte(input logic [7:0] b, input logic last);
      phase_type    entry_phase;
      int           n_before;
      rsp_item_type r;
      entry_phase = dec_phase;
      n_before = decoded_q.size();
      if (dec_err == ERR_NONE) begin
         case (dec_phase)
            PH_HDR0: begin
               raw_mode = (b == 8'd1);
               dec_phase = PH_HDR1;
            end
            PH_HDR1: dec_phase = PH_HDR2;
            PH_HDR2: dec_phase = PH_HDR3;
            PH_HDR3: begin
               if (raw_mode) dec_phase = PH_RAW;
               else dec_phase = PH_ITEM;
            end
            PH_RAW: take_literal(b);
            PH_ITEM: begin
               if (ctrl_left == 0) begin
                  ctrl_bits = {8'h00, b};
                  dec_phase = PH_CTRL_HIGH;
               end else if (ctrl_bits[0]) begin
                  copy_hi = b;
                  dec_phase = PH_COPY_B;
               end else begin
                  take_literal(b);
                  ctrl_bits = ctrl_bits >> 1;
                  ctrl_left = ctrl_left - 1'b1;
               end
            end
            PH_CTRL_HIGH: begin
               ctrl_bits[15:8] = b;
               ctrl_left = 5'd16;
               dec_phase = PH_ITEM;
            end
            PH_COPY_B: begin
               run_copy(b);
               ctrl_bits = ctrl_bits >> 1;
               ctrl_left = ctrl_left - 1'b1;
               dec_phase = PH_ITEM;
            end
         endcase
      end

      if (last) begin
         // a block closed inside its header, or halfway into a control word or copy
         if (dec_err == ERR_NONE) begin
            if (entry_phase <= PH_HDR3) dec_err = STS_SHORT;
            else if (dec_phase == PH_CTRL_HIGH || dec_phase == PH_COPY_B) dec_err = STS_TRUNC;
         end
         r = '0;
         if (dec_err == ERR_NONE) begin
            r.status = STS_OK;
            r.produced_total = out_count;
         end else begin
            r.status = dec_err;
         end
         decoded_q.push_back(r);
         out_count = '0;
         ctrl_bits = '0;
         ctrl_left = '0;
         dec_phase = PH_HDR0;
         raw_mode = 1'b0;
         copy_hi = '0;
         dec_err = ERR_NONE;
      end

      // the last result of this byte carries run_end
      if (decoded_q.size() > n_before) begin
         r = decoded_q.pop_back();
         r.run_end = 1'b1;
         decoded_q.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // stimulus construction
   // ------------------------------------------------------------------

   task automatic put(input logic [7:0] b);
      blk.push_back(b);
   endtask

   // hand the finished block to the driver, in_last on its final byte
   task automatic close_block();
      comp_byte_type c;
      for (int i = 0; i < blk.size(); i++) begin
         c.data = blk[i];
         c.last = (i == blk.size() - 1);
         compressed_q.push_back(c);
      end
      bytes_queued += blk.size();
      body_bytes += (blk.size() > 3) ? blk.size() - 3 : blk.size();
      blk.delete();
   endtask

   // fixed block, bytes listed first to last from the top of the vector
   task automatic send_block(input int n, input logic [127:0] bytes);
      for (int i = 0; i < n; i++) put(bytes[8*(n-1-i) +: 8]);
      close_block();
   endtask

   // compressed-mode header: first byte anything but 1
   task automatic lz_header();
      int hb;
      hb = $urandom_range(0, 254);
      if (hb != 0) hb = hb + 1;
      put(hb[7:0]);
      repeat (3) put(8'($urandom));
   endtask

   // control word plus n_items items; a cut group ends on the first byte of a copy
   task automatic lz_group(input int n_items, input logic cut_copy);
      logic [15:0] flags;
      logic [11:0] offset;
      logic [3:0]  len_m1;
      int unsigned reach;
      flags = 16'($urandom);
      // nothing to copy from until a byte exists
      for (int i = 0; i < n_items; i++)
         flags[i] = (lz_made != 0 || i != 0) && ($urandom_range(0, 9) < 4);
      if (cut_copy) flags[n_items] = 1'b1;
      put(flags[7:0]);
      put(flags[15:8]);
      for (int i = 0; i < n_items; i++) begin
         if (!flags[i]) begin
            put(8'($urandom));
            lz_made++;
         end else begin
            len_m1 = 4'($urandom);
            reach = (lz_made > 4095) ? 4095 : lz_made;
            case ($urandom_range(0, 29))
               0: offset = 12'd0;
               1: offset = (reach < 4095) ? 12'(reach + 1) : 12'd0;
               2, 3, 4, 5, 6, 7, 8, 9:
                  offset = 12'($urandom_range(1, (reach < 4) ? reach : 4));
               default: offset = 12'($urandom_range(1, reach));
            endcase
            put({offset[11:8], len_m1});
            put(offset[7:0]);
            lz_made += len_m1 + 1;
         end
      end
      if (cut_copy) put(8'($urandom));
   endtask

   task automatic gen_lz_block(input blk_end_type ending);
      lz_made = 0;
      lz_header();
      if ($urandom_range(0, 3) == 0) lz_group(16, 1'b0);
      case (ending)
         BLK_CUT_CTRL: put(8'($urandom));
         BLK_CUT_COPY: lz_group($urandom_range(0, 15), 1'b1);
         default: lz_group(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16), 1'b0);
      endcase
      close_block();
   endtask

   // mostly well-formed blocks, the rest pass-through, cut headers and noise
   task automatic random_blocks(input int budget);
      int target;
      int pick;
      int sel;
      target = body_bytes + budget;
      while (body_bytes < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) gen_lz_block(BLK_CUT_CTRL);
            else if (sel == 1) gen_lz_block(BLK_CUT_COPY);
            else gen_lz_block(BLK_OK);
         end else if (pick < 14) begin
            repeat ($urandom_range(1, 4)) put(8'($urandom));
            close_block();
         end else if (pick < 17) begin
            put(8'h01);
            repeat (3 + $urandom_range(1, 24)) put(8'($urandom));
            close_block();
         end else begin
            repeat ($urandom_range(1, 20)) put(8'($urandom));
            close_block();
         end
      end
   endtask

   // capacity register write, only issued with the block idle
   task automatic set_capacity(input logic [CAP_BITS-1:0] value);
      csr_out_capacity <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // every byte taken, every result back, then room for a refused copy to finish
   task automatic wait_idle();
      while (bytes_taken != bytes_queued || decoded_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // driver: one byte offered at a time, held until its transfer
   // ------------------------------------------------------------------
   always @(negedge clock) begin : driver
      comp_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (req_valid && !req_taken) begin
         // stalled, payload stays put
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         req_gap = $urandom_range(1, 7) - 1;
         req_valid <= 1'b0;
      end else if (compressed_q.size() != 0) begin
         nxt = compressed_q.pop_front();
         req_in_byte <= nxt.data;
         req_in_last <= nxt.last;
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // receiver: stall bursts, and one long hold-off that fills the block
   // ------------------------------------------------------------------
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else if (squeeze_rsp && !squeeze_done) begin
         squeeze_done = 1'b1;
         rsp_hold = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_hold = $urandom_range(1, 7) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // monitor: transfers seen at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            decode_byte(req_in_byte, req_in_last);
            bytes_taken++;
         end
         if (csr_valid && csr_ready) cap_reg = csr_out_capacity;
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: result with none expected, actual data %0h valid %0b status %0d",
                           $time, rsp_out_data, rsp_data_valid, rsp_status);
            end else begin
               want = decoded_q.pop_front();
               check_field("out_data", 32'(want.out_data), 32'(rsp_out_data));
               check_field("data_valid", 32'(want.data_valid), 32'(rsp_data_valid));
               check_field("status", 32'(want.status), 32'(rsp_status));
               check_field("produced_total", 32'(want.produced_total),
                           32'(rsp_produced_total));
               check_field("run_end", 32'(want.run_end), 32'(rsp_run_end));
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      set_capacity(24'hFFFFFF);

      // block ends on its first header byte
      send_block(1, 8'h00);
      // pass-through of both byte extremes, header bytes 1 to 3 ignored
      send_block(6, 48'h01_AA_55_00_00_FF);
      // two literals, overlapping copy of full length, then a copy cut after its first byte
      send_block(11, 88'h00_FF_80_7F_0C_00_00_FF_0F_02_3F);
      // block ends on a lone control word low byte
      send_block(5, 40'hFE_00_00_00_55);
      // zero offset after one literal, trailing byte ignored once the error is latched
      send_block(10, 80'h02_01_01_01_02_80_77_00_00_99);

      random_blocks(35);
      wait_idle();

      // nothing may be produced at all
      set_capacity(24'h000000);
      random_blocks(10);
      wait_idle();

      // small capacity: pass-through and copies run into the limit
      set_capacity(24'($urandom_range(1, 40)));
      random_blocks(20);
      wait_idle();

      // results held back long enough for the block to stall its input
      set_capacity(24'($urandom_range(64, 24'hFFFFFF)));
      squeeze_rsp = 1'b1;
      random_blocks(20);
      wait_idle();

      // last stretch at full rate on both sides
      set_capacity(24'hFFFFFF);
      calm = 1'b1;
      random_blocks(15);
      wait_idle();

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
